// ----- rtl/periodic_task_timer_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task timer table
// Shared property wrappers used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// check that a condition implies a consequence in the same cycle
`define PTT_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// check that a condition implies a consequence in the following cycle
`define PTT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table package
// Opcodes, status codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam logic [1:0] OP_SET      = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [2:0] ST_UPDATED    = 3'd0;
    localparam logic [2:0] ST_ADDED      = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_REJECTED   = 3'd3;
    localparam logic [2:0] ST_DELETED    = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [2:0] ST_TICKED     = 3'd6;
    localparam logic [2:0] ST_DISPATCHED = 3'd7;

    localparam int MAX_RESULTS = 16;

    // datapath commands
    typedef struct packed {
        logic load;       // capture input item, reset index
        logic advance;    // index++
        logic do_set;     // write entry at index (update) or at count (add)
        logic do_remove;  // remove entry at index
        logic do_tick;    // decrement entry at index
        logic tick_inc;   // tick counter++
        logic do_disp;    // rearm entry at index (periodic)
    } ptt_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       zero_id;
        logic       scan_done;  // index >= count
        logic       id_match;   // entry at index has id
        logic       ready;      // entry at index ready
        logic       one_shot;   // entry period zero
        logic       full;       // count == depth
    } ptt_sts_t;

endpackage

// ----- rtl/periodic_task_timer_table.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table
// Task table with set, delete, tick and dispatch commands.
// ----------------------------------------------------------------------------
// Each command walks the table one entry per cycle through a single scan
// index, while no held result blocks the scan. A set, delete or tick presents
// its result when its scan ends, and the next item is accepted only after
// that result is taken. A dispatch scan also waits on each emitted task
// while the output stalls.
module periodic_task_timer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // opcode, task_id, delay_value, period_value, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // run_id, run_valid, status, tick_count, pad
    output logic        m_tlast
);
    ptt_pkg::ptt_cmd_t cmd;
    ptt_pkg::ptt_sts_t sts;
    logic [7:0]  cur_id;
    logic [31:0] tick_count;
    logic [2:0]  status;
    logic        run_valid;
    logic [7:0]  run_id;

    ptt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .opcode(s_tdata[1:0]), .task_id(s_tdata[9:2]),
        .delay_value(s_tdata[41:10]), .period_value(s_tdata[73:42]),
        .cur_id(cur_id), .tick_count(tick_count)
    );

    ptt_controller u_ctl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(status), .out_run(run_valid), .out_last(m_tlast),
        .out_id(run_id), .cmd(cmd), .sts(sts), .cur_id(cur_id)
    );

    assign m_tdata = {4'd0, tick_count, status, run_valid, run_id};
endmodule

// ----- rtl/ptt_datapath.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table datapath
// Entry registers, scan index, captured item and tick counter.
// ----------------------------------------------------------------------------
module ptt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::ptt_cmd_t cmd,
    output ptt_pkg::ptt_sts_t sts,
    input  logic [1:0]        opcode,
    input  logic [7:0]        task_id,
    input  logic [31:0]       delay_value,
    input  logic [31:0]       period_value,
    output logic [7:0]        cur_id,
    output logic [31:0]       tick_count
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [7:0]  ids_reg     [TABLE_DEPTH];
    logic [31:0] delays_reg  [TABLE_DEPTH];
    logic [31:0] periods_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] ready_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   tick_reg;
    logic [1:0]    op_reg;
    logic [7:0]    id_reg;
    logic [31:0]   dly_reg;
    logic [31:0]   per_reg;

    logic [IW-1:0] ix;
    logic [IW-1:0] lastp;
    logic [IW-1:0] cx;
    logic [31:0]   dec;

    assign ix    = idx_reg[IW-1:0];
    assign lastp = IW'(count_reg - CW'(1));
    assign cx    = count_reg[IW-1:0];
    assign dec   = (delays_reg[ix] != 32'd0) ? delays_reg[ix] - 32'd1 : 32'd0;

    assign sts.opcode    = op_reg;
    assign sts.zero_id   = (id_reg == 8'd0);
    assign sts.scan_done = (idx_reg >= count_reg);
    assign sts.id_match  = (ids_reg[ix] == id_reg);
    assign sts.ready     = ready_reg[ix];
    assign sts.one_shot  = (periods_reg[ix] == 32'd0);
    assign sts.full      = (count_reg == CW'(TABLE_DEPTH));
    assign cur_id        = ids_reg[ix];
    assign tick_count    = tick_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            id_reg  <= task_id;
            dly_reg <= delay_value;
            per_reg <= period_value;
        end
        if (cmd.do_set)
        begin
            if (sts.scan_done)
            begin
                ids_reg[cx]     <= id_reg;
                delays_reg[cx]  <= dly_reg;
                periods_reg[cx] <= per_reg;
            end
            else
            begin
                delays_reg[ix]  <= dly_reg;
                periods_reg[ix] <= per_reg;
            end
        end
        if (cmd.do_remove && ix != lastp)
        begin
            ids_reg[ix]     <= ids_reg[lastp];
            delays_reg[ix]  <= delays_reg[lastp];
            periods_reg[ix] <= periods_reg[lastp];
        end
        if (cmd.do_tick)
            delays_reg[ix] <= dec;
        if (cmd.do_disp && delays_reg[ix] == 32'd0)
            delays_reg[ix] <= periods_reg[ix] - 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.advance)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.tick_inc)
                tick_reg <= tick_reg + 32'd1;
            if (cmd.do_set)
            begin
                if (sts.scan_done)
                begin
                    ready_reg[cx] <= 1'b0;
                    count_reg     <= count_reg + CW'(1);
                end
                else
                    ready_reg[ix] <= 1'b0;
            end
            if (cmd.do_remove)
            begin
                if (ix != lastp)
                    ready_reg[ix] <= ready_reg[lastp];
                ready_reg[lastp] <= 1'b0;
                count_reg        <= count_reg - CW'(1);
            end
            if (cmd.do_tick && dec == 32'd0)
                ready_reg[ix] <= 1'b1;
            if (cmd.do_disp)
                ready_reg[ix] <= 1'b0;
        end
    end

endmodule

// ----- rtl/ptt_controller.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer table controller
// Sequences the table scan for each command and drives the result stage.
// ----------------------------------------------------------------------------
`include "periodic_task_timer_table_assert.svh"
module ptt_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    output logic              out_run,
    output logic              out_last,
    output logic [7:0]        out_id,
    output ptt_pkg::ptt_cmd_t cmd,
    input  ptt_pkg::ptt_sts_t sts,
    input  logic [7:0]        cur_id
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [2:0] st_reg, st_next;
    logic       run_reg, run_next;
    logic       last_reg, last_next;
    logic [7:0] id_reg, id_next;
    logic [4:0] n_reg, n_next;

    logic emit;

    assign in_ready   = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid  = ov_reg;
    assign out_status = st_reg;
    assign out_run    = run_reg;
    assign out_last   = last_reg;
    assign out_id     = id_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        run_next   = run_reg;
        last_next  = last_reg;
        id_next    = id_reg;
        n_next     = n_reg;
        cmd        = '0;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    n_next     = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!ov_next)
                begin
                    unique case (sts.opcode)
                        ptt_pkg::OP_SET:
                        begin
                            if (sts.zero_id)
                            begin
                                emit = 1'b1; st_next = ptt_pkg::ST_REJECTED;
                            end
                            else if (!sts.scan_done && sts.id_match)
                            begin
                                cmd.do_set = 1'b1;
                                emit = 1'b1; st_next = ptt_pkg::ST_UPDATED;
                            end
                            else if (!sts.scan_done)
                                cmd.advance = 1'b1;
                            else if (sts.full)
                            begin
                                emit = 1'b1; st_next = ptt_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.do_set = 1'b1;
                                emit = 1'b1; st_next = ptt_pkg::ST_ADDED;
                            end
                            run_next = 1'b0; id_next = '0; last_next = 1'b1;
                        end
                        ptt_pkg::OP_DELETE:
                        begin
                            if (sts.zero_id || sts.scan_done)
                            begin
                                emit = 1'b1; st_next = ptt_pkg::ST_NOT_FOUND;
                            end
                            else if (sts.id_match)
                            begin
                                cmd.do_remove = 1'b1;
                                emit = 1'b1; st_next = ptt_pkg::ST_DELETED;
                            end
                            else
                                cmd.advance = 1'b1;
                            run_next = 1'b0; id_next = '0; last_next = 1'b1;
                        end
                        ptt_pkg::OP_TICK:
                        begin
                            if (sts.scan_done)
                            begin
                                emit = 1'b1; st_next = ptt_pkg::ST_TICKED;
                            end
                            else
                            begin
                                cmd.do_tick = 1'b1;
                                cmd.advance = 1'b1;
                            end
                            if (n_reg == 5'd0)
                            begin
                                cmd.tick_inc = 1'b1;
                                n_next = 5'd1;
                            end
                            run_next = 1'b0; id_next = '0; last_next = 1'b1;
                        end
                        default:
                        begin
                            if (sts.scan_done || n_reg == 5'(ptt_pkg::MAX_RESULTS))
                            begin
                                if (n_reg == 5'd0)
                                begin
                                    emit = 1'b1; run_next = 1'b0; id_next = '0;
                                    last_next = 1'b1; st_next = ptt_pkg::ST_DISPATCHED;
                                end
                                else
                                    state_next = S_IDLE;
                            end
                            else if (sts.ready)
                            begin
                                ov_next   = 1'b1;
                                run_next  = 1'b1;
                                id_next   = cur_id;
                                st_next   = ptt_pkg::ST_DISPATCHED;
                                last_next = 1'b0;
                                n_next    = n_reg + 5'd1;
                                cmd.advance = 1'b1;
                                if (sts.one_shot)
                                    cmd.do_remove = 1'b1;
                                else
                                    cmd.do_disp = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                                cmd.advance = 1'b1;
                        end
                    endcase
                    if (emit)
                    begin
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                // decide last of the held dispatch result before showing it
                if (sts.scan_done || n_reg == 5'(ptt_pkg::MAX_RESULTS))
                begin
                    ov_next    = 1'b1;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    cmd.advance = 1'b1;
            end
        endcase
    end

    // hold the dispatch result back until its last flag is known
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next && (state_next != S_OUT);
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        run_reg  <= run_next;
        last_reg <= last_next;
        id_reg   <= id_next;
    end

    `PTT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready, "busy accept")
    `PTT_ASSERT_IMP(a_run_id, clk, rst_n, out_valid && out_run, out_id != 8'd0, "zero run id")
    `PTT_ASSERT_NEXT(a_load_scan, clk, rst_n, in_valid && in_ready, state_reg == S_SCAN, "no scan")
endmodule

// ----- tb/ptt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task timer table checker
// Watches both stream channels, keeps a shadow task table, predicts the
// results of each accepted command and compares every returned transfer.
// ----------------------------------------------------------------------------
module ptt_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          runs_seen
);

    typedef struct {
        logic [7:0]  run_id;
        logic        run_valid;
        logic [2:0]  status;
        logic [31:0] tick_count;
        logic        last;
    } task_result_t;

    task_result_t expected_results[$];

    logic [7:0]  shadow_ids     [TABLE_DEPTH];
    logic [31:0] shadow_delays  [TABLE_DEPTH];
    logic [31:0] shadow_periods [TABLE_DEPTH];
    logic        shadow_ready   [TABLE_DEPTH];
    int          shadow_count;
    logic [31:0] shadow_ticks;

    function automatic int lookup_slot(logic [7:0] id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_ids[i] == id)
                return i;
        return TABLE_DEPTH;
    endfunction

    function automatic void drop_slot(int i);
        int tail;
        tail = shadow_count - 1;
        if (i != tail)
        begin
            shadow_ids[i]     = shadow_ids[tail];
            shadow_delays[i]  = shadow_delays[tail];
            shadow_periods[i] = shadow_periods[tail];
            shadow_ready[i]   = shadow_ready[tail];
        end
        shadow_ready[tail] = 1'b0;
        shadow_count = tail;
    endfunction

    function automatic void push_result(logic [7:0] id, logic vld, logic [2:0] st);
        task_result_t r;
        r.run_id     = id;
        r.run_valid  = vld;
        r.status     = st;
        r.tick_count = shadow_ticks;
        r.last       = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_command(logic [1:0] op, logic [7:0] id,
                                            logic [31:0] dly, logic [31:0] per);
        int          i;
        int          n;
        logic [2:0]  st;
        n = 0;
        case (op)
            ptt_pkg::OP_SET:
            begin
                if (id == 8'd0)
                    st = ptt_pkg::ST_REJECTED;
                else
                begin
                    i = lookup_slot(id);
                    if (i < TABLE_DEPTH)
                        st = ptt_pkg::ST_UPDATED;
                    else if (shadow_count < TABLE_DEPTH)
                    begin
                        i = shadow_count;
                        shadow_ids[i] = id;
                        shadow_count++;
                        st = ptt_pkg::ST_ADDED;
                    end
                    else
                        st = ptt_pkg::ST_FULL;
                    if (st != ptt_pkg::ST_FULL)
                    begin
                        shadow_delays[i]  = dly;
                        shadow_periods[i] = per;
                        shadow_ready[i]   = 1'b0;
                    end
                end
                push_result(8'd0, 1'b0, st);
                n = 1;
            end
            ptt_pkg::OP_DELETE:
            begin
                i = (id == 8'd0) ? TABLE_DEPTH : lookup_slot(id);
                if (i < TABLE_DEPTH)
                begin
                    drop_slot(i);
                    st = ptt_pkg::ST_DELETED;
                end
                else
                    st = ptt_pkg::ST_NOT_FOUND;
                push_result(8'd0, 1'b0, st);
                n = 1;
            end
            ptt_pkg::OP_TICK:
            begin
                shadow_ticks++;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_delays[i] != 32'd0)
                        shadow_delays[i]--;
                    if (shadow_delays[i] == 32'd0)
                        shadow_ready[i] = 1'b1;
                end
                push_result(8'd0, 1'b0, ptt_pkg::ST_TICKED);
                n = 1;
            end
            default:
            begin
                // a removed slot takes the tail entry, which this scan then skips
                for (i = 0; i < shadow_count && n < ptt_pkg::MAX_RESULTS; i++)
                begin
                    if (!shadow_ready[i])
                        continue;
                    push_result(shadow_ids[i], 1'b1, ptt_pkg::ST_DISPATCHED);
                    n++;
                    if (shadow_periods[i] == 32'd0)
                        drop_slot(i);
                    else
                    begin
                        shadow_ready[i] = 1'b0;
                        if (shadow_delays[i] == 32'd0)
                            shadow_delays[i] = shadow_periods[i] - 32'd1;
                    end
                end
                if (n == 0)
                    push_result(8'd0, 1'b0, ptt_pkg::ST_DISPATCHED);
            end
        endcase
        expected_results[$].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        task_result_t want;
        task_result_t got;
        if (!rst_n)
        begin
            expected_results.delete();
            for (int i = 0; i < TABLE_DEPTH; i++)
                shadow_ready[i] = 1'b0;
            shadow_count = 0;
            shadow_ticks = '0;
            fail_count   = 0;
            results_seen = 0;
            runs_seen    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.run_id     = m_tdata[7:0];
                got.run_valid  = m_tdata[8];
                got.status     = m_tdata[11:9];
                got.tick_count = m_tdata[43:12];
                got.last       = m_tlast;
                results_seen++;
                if (got.run_valid)
                    runs_seen++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer id=%0d valid=%0b status=%0d",
                             $time, got.run_id, got.run_valid, got.status,
                             " tick=%0d last=%0b", got.tick_count, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.run_id !== got.run_id || want.run_valid !== got.run_valid ||
                        want.status !== got.status || want.tick_count !== got.tick_count ||
                        want.last !== got.last)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected id=%0d valid=%0b status=%0d",
                                 $time, want.run_id, want.run_valid, want.status,
                                 " tick=%0d last=%0b", want.tick_count, want.last);
                        $display("%0t:          actual   id=%0d valid=%0b status=%0d",
                                 $time, got.run_id, got.run_valid, got.status,
                                 " tick=%0d last=%0b", got.tick_count, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tdata[1:0], s_tdata[9:2], s_tdata[41:10], s_tdata[73:42]);
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/tb_periodic_task_timer_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task timer table testbench
// Drives set, delete, tick and dispatch commands with bursty input and a
// stalling output, and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 134;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int pending;
    int results_seen;
    int runs_seen;
    int items_sent;
    int idle_cycles;
    logic hold_req;

    periodic_task_timer_table #(
        .TABLE_DEPTH(16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ptt_checker #(
        .TABLE_DEPTH(16)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .runs_seen    (runs_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("periodic_task_timer_table regression: fail");
            $finish;
        end
    end

    // output stall pattern, plus one long hold-off on request
    initial
    begin
        int  mode;
        int  left;
        bit  hold_done;
        m_tready  = 1'b0;
        hold_done = 0;
        mode      = 0;
        left      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    int burst_left;

    task automatic send_command(logic [1:0] op, logic [7:0] id,
                                logic [31:0] dly, logic [31:0] per);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, per, dly, id, op};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 20));
    endfunction

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom();
        if (r == 1)
            return 32'hFFFF_FFFF;
        return 32'($urandom_range(0, 5));
    endfunction

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom();
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r < 8)
            return 32'd0;
        return 32'($urandom_range(1, 4));
    endfunction

    initial
    begin
        int r;
        logic [1:0] op;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_req   = 1'b0;
        items_sent = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(ptt_pkg::OP_SET, 8'd0, 32'd3, 32'd3);
        send_command(ptt_pkg::OP_DELETE, 8'd0, 32'd0, 32'd0);
        send_command(ptt_pkg::OP_DELETE, 8'd77, 32'd0, 32'd0);
        send_command(ptt_pkg::OP_DISPATCH, 8'd0, 32'd0, 32'd0);
        for (int i = 1; i <= 16; i++)
            send_command(ptt_pkg::OP_SET, 8'(i == 16 ? 255 : i), 32'(i % 3), 32'(i % 2));
        send_command(ptt_pkg::OP_SET, 8'd200, 32'd1, 32'd1);
        send_command(ptt_pkg::OP_SET, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(ptt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0);
        send_command(ptt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0);
        send_command(ptt_pkg::OP_DISPATCH, 8'd0, 32'd0, 32'd0);
        send_command(ptt_pkg::OP_DELETE, 8'd4, 32'd0, 32'd0);
        pause_sender();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 60)
                hold_req <= 1'b1;
            if (k == 110)
                pause_sender();
            r = $urandom_range(0, 99);
            if (r < 35)
                op = ptt_pkg::OP_SET;
            else if (r < 50)
                op = ptt_pkg::OP_DELETE;
            else if (r < 78)
                op = ptt_pkg::OP_TICK;
            else
                op = ptt_pkg::OP_DISPATCH;
            send_command(op, pick_id(), pick_delay(), pick_period());
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d commands; checked %0d result transfers, %0d of them task runs.",
                 items_sent, results_seen, runs_seen);
        if (fail_count == 0)
            $display("periodic_task_timer_table regression: pass");
        else
            $display("periodic_task_timer_table regression: fail");
        $finish;
    end

endmodule
